FILE: hdl/meg_pkg.sv
// Shared types and constants for the modular exponentiation / ElGamal core.
// No dependencies; used by meg_mulmod and modexp_elgamal_cipher_core.
package meg_pkg;

    // command codes
    localparam logic [1:0] CMD_POWER   = 2'd0;
    localparam logic [1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [1:0] CMD_DECRYPT = 2'd2;

    // multiply-reduce unit states
    typedef enum logic [2:0] {
        MM_IDLE = 3'b001,
        MM_MUL  = 3'b010,
        MM_RED  = 3'b100
    } t_mm_state;

    // top-level sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_STEP  = 7'b0000100,
        S_WACC  = 7'b0001000,
        S_WSQR  = 7'b0010000,
        S_WFIN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_seq_state;

    // status of the multiply-reduce unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

FILE: hdl/meg_if.sv
// Valid/ready channel interfaces for the core's request and result beats.
// No dependencies.
interface meg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] base;
    logic [31:0] exponent;
    logic [31:0] modulus;
    logic [31:0] value;
    logic        last_in;

    modport source (output valid, command, base, exponent, modulus, value, last_in,
                    input ready);
    modport sink   (input valid, command, base, exponent, modulus, value, last_in,
                    output ready);
endinterface

interface meg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        error;
    logic        last_out;

    modport source (output valid, result, error, last_out, input ready);
    modport sink   (input valid, result, error, last_out, output ready);
endinterface

FILE: hdl/meg_mulmod.sv
// Shared multiply-reduce unit: (a * b) mod m, one product then a bit-serial
// restoring reduction of 2W bits. Depends on meg_pkg.
module meg_mulmod #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_a,
    input  logic [W-1:0]        i_b,
    input  logic [W-1:0]        i_m,
    output meg_pkg::t_mm_stat   o_stat,
    output logic [W-1:0]        o_res
);
    localparam int CW = $clog2(2 * W + 1);

    meg_pkg::t_mm_state r_state, n_state;
    logic [W-1:0]   r_a, n_a, r_b, n_b, r_m, n_m;
    logic [2*W-1:0] r_prod, n_prod;
    logic [W:0]     r_rem, n_rem;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_done, n_done;
    logic [W:0]     rem_sh;

    assign rem_sh = {r_rem[W-1:0], r_prod[2*W-1]};

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_m     = r_m;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            meg_pkg::MM_IDLE: begin
                if (i_start) begin
                    n_a     = i_a;
                    n_b     = i_b;
                    n_m     = i_m;
                    n_state = meg_pkg::MM_MUL;
                end
            end
            meg_pkg::MM_MUL: begin
                n_prod  = {{W{1'b0}}, r_a} * {{W{1'b0}}, r_b};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = meg_pkg::MM_RED;
            end
            meg_pkg::MM_RED: begin
                n_prod = {r_prod[2*W-2:0], 1'b0};
                n_rem  = (rem_sh >= {1'b0, r_m}) ? rem_sh - {1'b0, r_m} : rem_sh;
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(2 * W - 1)) begin
                    n_done  = 1'b1;
                    n_state = meg_pkg::MM_IDLE;
                end
            end
            default: n_state = meg_pkg::MM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= meg_pkg::MM_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_m    <= n_m;
        r_prod <= n_prod;
        r_rem  <= n_rem;
    end

    assign o_stat.busy = (r_state != meg_pkg::MM_IDLE);
    assign o_stat.done = r_done;
    assign o_res       = r_rem[W-1:0];

    // remainder is always reduced below the modulus
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, r_m}))
        else $error("mulmod remainder not reduced");

    // a finished job is flagged only while the unit is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == meg_pkg::MM_IDLE))
        else $error("mulmod done outside idle");

    // the product step is followed by reduction with the step counter cleared
    a_mul_to_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == meg_pkg::MM_MUL) |=> (r_state == meg_pkg::MM_RED && r_cnt == '0))
        else $error("mulmod product step did not enter reduction");

endmodule

FILE: hdl/modexp_elgamal_cipher_core.sv
// Top level: modular power, ElGamal element encrypt and decrypt, sequenced
// over one shared multiply-reduce unit. Depends on meg_pkg, meg_if, meg_mulmod.
//
//  channel  | dir | beat contents                                   | handshake
//  ---------+-----+-------------------------------------------------+----------
//  i_in     | in  | command, base, exponent, modulus, value, last_in | valid/ready
//  o_out    | out | result, error, last_out                          | valid/ready
//
// Steps: one multiply on meg_mulmod is a product step, 2*OPERAND_WIDTH reduction
//   steps and a done strobe. An item takes up to 2*OPERAND_WIDTH multiplies; a power
//   with zero exponent, a zero modulus and errors are settled without the unit.
// Reset: synchronous active-low i_rst_n clears sequencer and output valid.
// Stalls: a request is taken only in idle; a finished result waits in the
//   output register, and the next request may start while it waits.
module modexp_elgamal_cipher_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    meg_in_if.sink        i_in,
    meg_out_if.source     o_out
);
    localparam int W = OPERAND_WIDTH;

    meg_pkg::t_seq_state r_state, n_state;

    // working operands, cut to W bits
    logic [1:0]   r_cmd, n_cmd;
    logic [W-1:0] r_b, n_b;      // running base (squared each step)
    logic [W-1:0] r_e, n_e;      // remaining exponent bits
    logic [W-1:0] r_m, n_m;
    logic [W-1:0] r_v, n_v;
    logic [W-1:0] r_acc, n_acc;  // running product
    logic         r_last, n_last;
    logic [W-1:0] r_res, n_res;
    logic         r_err, n_err;

    // output register
    logic         r_o_valid, n_o_valid;
    logic [31:0]  r_o_result, n_o_result;
    logic         r_o_error, n_o_error;
    logic         r_o_last, n_o_last;

    // shared unit
    logic              mm_start;
    logic [W-1:0]      mm_a, mm_b, mm_res;
    meg_pkg::t_mm_stat mm_stat;

    logic accept;
    logic out_load;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == meg_pkg::S_IDLE);
    assign out_load    = (r_state == meg_pkg::S_DONE) && (!r_o_valid || o_out.ready);

    meg_mulmod #(.W(W)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (r_m),
        .o_stat  (mm_stat),
        .o_res   (mm_res)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_b        = r_b;
        n_e        = r_e;
        n_m        = r_m;
        n_v        = r_v;
        n_acc      = r_acc;
        n_last     = r_last;
        n_res      = r_res;
        n_err      = r_err;
        n_o_valid  = r_o_valid;
        n_o_result = r_o_result;
        n_o_error  = r_o_error;
        n_o_last   = r_o_last;
        mm_start   = 1'b0;
        mm_a       = r_acc;
        mm_b       = r_b;

        // downstream drains the output register
        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            meg_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_in.command;
                    n_b     = i_in.base[W-1:0];
                    n_e     = i_in.exponent[W-1:0];
                    n_m     = i_in.modulus[W-1:0];
                    n_v     = i_in.value[W-1:0];
                    n_last  = i_in.last_in;
                    n_state = meg_pkg::S_CHECK;
                end
            end
            meg_pkg::S_CHECK: begin
                // settle the short cases; otherwise start square-and-multiply
                n_acc   = W'(1);
                n_res   = '0;
                n_err   = 1'b0;
                n_state = meg_pkg::S_STEP;
                case (r_cmd)
                    meg_pkg::CMD_POWER: begin
                        if (r_e == '0) begin
                            n_res   = W'(1);   // unreduced even for modulus 1
                            n_state = meg_pkg::S_DONE;
                        end else if (r_m == '0) begin
                            n_state = meg_pkg::S_DONE;
                        end
                    end
                    meg_pkg::CMD_ENCRYPT: begin
                        if (r_m == '0) begin
                            n_state = meg_pkg::S_DONE;
                        end
                    end
                    meg_pkg::CMD_DECRYPT: begin
                        if (r_m < W'(2)) begin
                            n_err   = 1'b1;
                            n_state = meg_pkg::S_DONE;
                        end else begin
                            n_e = r_m - W'(2);  // Fermat inverse exponent
                        end
                    end
                    default: n_state = meg_pkg::S_DONE;  // unused code
                endcase
            end
            meg_pkg::S_STEP: begin
                if (r_e == '0) begin
                    if (r_cmd == meg_pkg::CMD_POWER) begin
                        n_res   = r_acc;
                        n_state = meg_pkg::S_DONE;
                    end else begin
                        // (v mod m) * p mod m == v * p mod m
                        mm_start = 1'b1;
                        mm_a     = r_v;
                        mm_b     = r_acc;
                        n_state  = meg_pkg::S_WFIN;
                    end
                end else if (r_e[0]) begin
                    mm_start = 1'b1;
                    mm_a     = r_acc;
                    mm_b     = r_b;
                    n_state  = meg_pkg::S_WACC;
                end else begin
                    mm_start = 1'b1;
                    mm_a     = r_b;
                    mm_b     = r_b;
                    n_e      = r_e >> 1;
                    n_state  = meg_pkg::S_WSQR;
                end
            end
            meg_pkg::S_WACC: begin
                if (mm_stat.done) begin
                    n_acc = mm_res;
                    n_e   = r_e >> 1;
                    if ((r_e >> 1) == '0) begin
                        n_state = meg_pkg::S_STEP;   // final square not needed
                    end else begin
                        mm_start = 1'b1;
                        mm_a     = r_b;
                        mm_b     = r_b;
                        n_state  = meg_pkg::S_WSQR;
                    end
                end
            end
            meg_pkg::S_WSQR: begin
                if (mm_stat.done) begin
                    n_b     = mm_res;
                    n_state = meg_pkg::S_STEP;
                end
            end
            meg_pkg::S_WFIN: begin
                if (mm_stat.done) begin
                    n_res = (r_cmd == meg_pkg::CMD_DECRYPT) ? W'(mm_res[7:0]) : mm_res;
                    n_state = meg_pkg::S_DONE;
                end
            end
            meg_pkg::S_DONE: begin
                if (out_load) begin
                    n_o_valid  = 1'b1;
                    n_o_result = 32'(r_res);
                    n_o_error  = r_err;
                    n_o_last   = r_last;
                    n_state    = meg_pkg::S_IDLE;
                end
            end
            default: n_state = meg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= meg_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_b        <= n_b;
        r_e        <= n_e;
        r_m        <= n_m;
        r_v        <= n_v;
        r_acc      <= n_acc;
        r_last     <= n_last;
        r_res      <= n_res;
        r_err      <= n_err;
        r_o_result <= n_o_result;
        r_o_error  <= n_o_error;
        r_o_last   <= n_o_last;
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.result   = r_o_result;
    assign o_out.error    = r_o_error;
    assign o_out.last_out = r_o_last;

    // the shared unit is only started when free
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_start |-> !mm_stat.busy)
        else $error("multiply started while unit busy");

    // the unit is never started with a zero modulus
    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_start |-> (r_m != '0))
        else $error("multiply started with zero modulus");

    // a flagged beat carries a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_err |=> (o_out.result == 32'd0))
        else $error("error beat with nonzero result");

    // a decrypted character fits in 8 bits
    a_dec_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && (r_cmd == meg_pkg::CMD_DECRYPT) |=> (o_out.result[31:8] == 24'd0))
        else $error("decrypt result wider than a byte");

endmodule
